// File: rtl/rtcp_pkg.sv
// ----------------------------------------------------------------------------
// rtcp_pkg
// shared types and constants of the rtcp compound packet parser
// ----------------------------------------------------------------------------
package rtcp_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam logic [7:0] PtFirst = 8'd200;
	localparam logic [7:0] PtLast = 8'd205;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SDES = 2'd1,
		KIND_SEQ = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	localparam logic [2:0] TypeSdes = 3'd2;
	localparam logic [2:0] TypeNack = 3'd5;

	localparam logic ErrUnknown = 1'b0;
	localparam logic ErrTrunc = 1'b1;

	typedef enum logic [1:0] {
		SDES_TYPE = 2'd0,
		SDES_LEN = 2'd1,
		SDES_TEXT = 2'd2,
		SDES_DONE = 2'd3
	} sdes_t;

	// one classified job handed from the front to the back
	typedef struct packed {
		kind_t kind;
		logic [2:0] packet_type;
		logic [4:0] count_fmt;
		logic [15:0] length_words;
		logic [1:0] version;
		logic padding;
		logic [7:0] item_type;
		logic [7:0] item_length;
		logic [15:0] pid;
		logic [15:0] blp;
		logic error_code;
		logic hdr_last;
	} job_t;

	typedef struct packed {
		kind_t kind;
		logic [2:0] packet_type;
		logic [4:0] count_fmt;
		logic [15:0] length_words;
		logic [1:0] version;
		logic padding;
		logic [7:0] item_type;
		logic [7:0] item_length;
		logic [15:0] seq_number;
		logic error_code;
		logic last;
	} rec_t;

endpackage

// File: rtl/rtcp_front.sv
// ----------------------------------------------------------------------------
// rtcp_front
// byte walker: decodes headers, sdes items, nack fci and errors into jobs
// ----------------------------------------------------------------------------
module rtcp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] data_byte,
	input logic end_of_datagram,
	output logic job_valid,
	output rtcp_pkg::job_t job
);

	logic [17:0] pos_q, pbytes_q;
	logic [31:0] hdr_q;
	logic [2:0] type_q;
	rtcp_pkg::sdes_t sdes_q;
	logic [7:0] srem_q;
	logic [15:0] nack_q;
	logic [7:0] blp_hi_q;
	logic stop_q;

	logic [31:0] hdr_n;
	logic [7:0] pt;
	logic [2:0] type_c;
	logic [17:0] pbytes_c;
	logic bad, trunc, hdr_job, sdes_job, nack_job;

	always_comb begin
		hdr_n = pos_q <= 18'd3 ? {hdr_q[23:0], data_byte} : hdr_q;
		pt = hdr_n[23:16];
		bad = (pt < rtcp_pkg::PtFirst) || (pt > rtcp_pkg::PtLast);
		type_c = (pos_q == 18'd3) ? 3'(pt - rtcp_pkg::PtFirst) : type_q;
		pbytes_c = (pos_q == 18'd3) ? {hdr_n[15:0], 2'b11} : pbytes_q;
		trunc = end_of_datagram && (pos_q < 18'd3 || pos_q < pbytes_c);
		hdr_job = pos_q == 18'd3;
		sdes_job = type_c == rtcp_pkg::TypeSdes && pos_q >= 18'd8
			&& sdes_q == rtcp_pkg::SDES_LEN && pos_q != 18'd3;
		nack_job = type_c == rtcp_pkg::TypeNack && pos_q == 18'd15;
		job = '0;
		job.packet_type = type_c;
		job_valid = 1'b0;
		if (in_valid && !stop_q) begin
			if (hdr_job && bad) begin
				job_valid = 1'b1;
				job.kind = rtcp_pkg::KIND_ERROR;
				job.packet_type = '0;
				job.error_code = rtcp_pkg::ErrUnknown;
				job.hdr_last = 1'b1;
			end else if (trunc) begin
				job_valid = 1'b1;
				job.kind = rtcp_pkg::KIND_ERROR;
				job.packet_type = '0;
				job.error_code = rtcp_pkg::ErrTrunc;
				job.hdr_last = 1'b1;
			end else if (hdr_job) begin
				job_valid = 1'b1;
				job.kind = rtcp_pkg::KIND_HEADER;
				job.count_fmt = hdr_n[28:24];
				job.length_words = hdr_n[15:0];
				job.version = hdr_n[31:30];
				job.padding = hdr_n[29];
				job.hdr_last = 1'b1;
			end else if (sdes_job) begin
				job_valid = 1'b1;
				job.kind = rtcp_pkg::KIND_SDES;
				job.item_type = srem_q;
				job.item_length = data_byte;
				job.hdr_last = 1'b1;
			end else if (nack_job) begin
				job_valid = 1'b1;
				job.kind = rtcp_pkg::KIND_SEQ;
				job.pid = nack_q;
				job.blp = {blp_hi_q, data_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pbytes_q <= '0;
			hdr_q <= '0;
			type_q <= '0;
			sdes_q <= rtcp_pkg::SDES_TYPE;
			srem_q <= '0;
			nack_q <= '0;
			blp_hi_q <= '0;
			stop_q <= 1'b0;
		end else if (in_valid) begin
			if (stop_q || (hdr_job && bad) || trunc || end_of_datagram) begin
				pos_q <= '0;
				pbytes_q <= '0;
				hdr_q <= '0;
				type_q <= '0;
				sdes_q <= rtcp_pkg::SDES_TYPE;
				srem_q <= '0;
				nack_q <= '0;
				blp_hi_q <= '0;
				// stays stopped until the datagram ends
				stop_q <= !end_of_datagram && (stop_q || (hdr_job && bad));
			end else begin
				hdr_q <= hdr_n;
				type_q <= type_c;
				pbytes_q <= pbytes_c;
				if (hdr_job) begin
					sdes_q <= rtcp_pkg::SDES_TYPE;
					srem_q <= '0;
				end
				if (type_c == rtcp_pkg::TypeSdes && pos_q >= 18'd8) begin
					case (sdes_q)
						rtcp_pkg::SDES_TYPE: begin
							srem_q <= data_byte;
							sdes_q <= data_byte == 8'd0 ? rtcp_pkg::SDES_DONE
								: rtcp_pkg::SDES_LEN;
						end
						rtcp_pkg::SDES_LEN: begin
							srem_q <= data_byte;
							sdes_q <= data_byte != 8'd0 ? rtcp_pkg::SDES_TEXT
								: rtcp_pkg::SDES_TYPE;
						end
						rtcp_pkg::SDES_TEXT: begin
							srem_q <= srem_q - 8'd1;
							if (srem_q == 8'd1)
								sdes_q <= rtcp_pkg::SDES_TYPE;
						end
						default: ;
					endcase
				end
				if (type_c == rtcp_pkg::TypeNack && pos_q >= 18'd12 && pos_q <= 18'd13)
					nack_q <= {nack_q[7:0], data_byte};
				if (type_c == rtcp_pkg::TypeNack && pos_q == 18'd14)
					blp_hi_q <= data_byte;
				if (pos_q >= 18'd3 && pos_q == pbytes_c)
					pos_q <= '0;
				else
					pos_q <= pos_q + 18'd1;
			end
		end
	end

endmodule

// File: rtl/rtcp_queue.sv
// ----------------------------------------------------------------------------
// rtcp_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module rtcp_queue #(
	parameter int unsigned Depth = rtcp_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input rtcp_pkg::job_t wr_data,
	output logic full,
	input logic rd_en,
	output logic empty,
	output rtcp_pkg::job_t rd_data
);

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	rtcp_pkg::job_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0] cnt_q;

	assign full = cnt_q == (Aw+1)'(Depth);
	assign empty = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !empty)
				rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(wr_en && !full) - (Aw+1)'(rd_en && !empty);
		end
	end

endmodule

// File: rtl/rtcp_back.sv
// ----------------------------------------------------------------------------
// rtcp_back
// turns jobs into records; a nack gives one set blp bit per cycle on rec_ready
// ----------------------------------------------------------------------------
module rtcp_back (
	input logic clk,
	input logic arst_n,
	input logic job_present,
	input rtcp_pkg::job_t job,
	output logic job_take,
	output logic rec_valid,
	output rtcp_pkg::rec_t rec,
	input logic rec_ready
);

	// expansion step: 0 = pid, 1..16 = blp bit idx-1
	logic [4:0] idx_q;
	logic is_seq, emit;

	always_comb begin
		is_seq = job.kind == rtcp_pkg::KIND_SEQ;
		emit = job_present;
		rec = '0;
		rec.kind = job.kind;
		rec.packet_type = job.packet_type;
		rec.count_fmt = job.count_fmt;
		rec.length_words = job.length_words;
		rec.version = job.version;
		rec.padding = job.padding;
		rec.item_type = job.item_type;
		rec.item_length = job.item_length;
		rec.error_code = job.error_code;
		rec.last = job.hdr_last;
		if (is_seq) begin
			rec.seq_number = (idx_q == '0) ? job.pid : job.pid + 16'(idx_q);
			// find next after this emission
			rec.last = 1'b1;
			for (int i = 0; i < 16; i++)
				if (job.blp[i] && 5'(i) + 5'd1 > idx_q)
					rec.last = 1'b0;
		end
		rec_valid = emit;
		job_take = emit && rec_ready && rec.last;
	end

	logic [4:0] idx_n;
	always_comb begin
		idx_n = 5'd16;
		for (int i = 15; i >= 0; i--)
			if (job.blp[i] && 5'(i) + 5'd1 > idx_q)
				idx_n = 5'(i) + 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (rec_valid && rec_ready && is_seq)
			idx_q <= rec.last ? 5'd0 : idx_n;
	end

endmodule

// File: rtl/rtcp_compound_packet_parser_top.sv
// ----------------------------------------------------------------------------
// rtcp_compound_packet_parser_top
// rtcp compound datagram parser, one byte per transfer
// ----------------------------------------------------------------------------
// usage:
//   input channel: push with data_byte and end_of_datagram; a transfer
//   happens when push is high and full is low
//   result channel: empty/pop; the oldest record sits on the ports while
//   empty is low and is consumed by a transfer with pop high
//   a byte's job is registered in the job queue, and its record shows once older records have been popped
//   throughput: one byte per cycle while full is low; a nack fci expands
//   into one record per cycle while pop is high (pid, then each set blp
//   bit) in the back end; full rises when the job queue fills, e.g. while
//   the consumer stalls or a nack expansion is in progress
//   reset clears the byte walker, the job queue and the expansion counter
//   each byte makes at most one job; the queue parts the walker from the
//   record output so either side may stall on its own
// ----------------------------------------------------------------------------
module rtcp_compound_packet_parser_top #(
	parameter int unsigned QueueDepth = rtcp_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic end_of_datagram,
	output logic empty,
	input logic pop,
	output logic [1:0] kind,
	output logic [2:0] packet_type,
	output logic [4:0] count_fmt,
	output logic [15:0] length_words,
	output logic [1:0] version,
	output logic padding,
	output logic [7:0] item_type,
	output logic [7:0] item_length,
	output logic [15:0] seq_number,
	output logic error_code,
	output logic last
);

	logic job_valid, q_full, q_empty, job_take, rec_valid;
	rtcp_pkg::job_t job, q_job;
	rtcp_pkg::rec_t rec;

	// stall input whenever the queue cannot take a job
	assign full = q_full;

	rtcp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push && !q_full),
		.data_byte(data_byte), .end_of_datagram(end_of_datagram),
		.job_valid(job_valid), .job(job)
	);

	rtcp_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_valid), .wr_data(job), .full(q_full),
		.rd_en(job_take), .empty(q_empty), .rd_data(q_job)
	);

	rtcp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_present(!q_empty), .job(q_job), .job_take(job_take),
		.rec_valid(rec_valid), .rec(rec), .rec_ready(pop)
	);

	assign empty = !rec_valid;
	assign kind = rec.kind;
	assign packet_type = rec.packet_type;
	assign count_fmt = rec.count_fmt;
	assign length_words = rec.length_words;
	assign version = rec.version;
	assign padding = rec.padding;
	assign item_type = rec.item_type;
	assign item_length = rec.item_length;
	assign seq_number = rec.seq_number;
	assign error_code = rec.error_code;
	assign last = rec.last;

endmodule

// File: rtl/rtcp_checker.sv
// ----------------------------------------------------------------------------
// rtcp_checker
// port-level checks of the parser
// ----------------------------------------------------------------------------
module rtcp_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [1:0] kind,
	input logic [15:0] seq_number,
	input logic error_code,
	input logic last
);

	// a waiting record stays until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("record dropped");
	a_hold_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(kind)) else $error("record changed");
	// errors and headers are single records
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == rtcp_pkg::KIND_ERROR || kind == rtcp_pkg::KIND_HEADER)
		|-> last) else $error("bad last");
	a_seq_only: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != rtcp_pkg::KIND_SEQ |-> seq_number == '0)
		else $error("stray seq");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != rtcp_pkg::KIND_ERROR |-> !error_code)
		else $error("stray code");

endmodule

bind rtcp_compound_packet_parser_top rtcp_checker u_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .kind(kind),
	.seq_number(seq_number), .error_code(error_code), .last(last)
);
